// ===== rtl/aralloc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package aralloc_pkg;

   localparam int AddrWidth       = 32;
   localparam int AlignCfgWidth   = 31;
   localparam int FragCountWidth  = 7;
   localparam int DefMaxFragments = 64;

   typedef enum logic [1:0] {
      OP_ALLOC    = 2'd0,
      OP_ALLOC_AT = 2'd1,
      OP_FREE     = 2'd2,
      OP_QUERY    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP1,
      ST_PREP2,
      ST_PREP3,
      ST_READ,
      ST_EVAL1,
      ST_EVAL2,
      ST_CARVE,
      ST_DEC,
      ST_SHUP_RD,
      ST_SHUP_WR,
      ST_SHDN_RD,
      ST_SHDN_WR,
      ST_WR0,
      ST_WR1,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type                 opcode;
      logic [AddrWidth-1:0]   address;
      logic [AddrWidth-1:0]   size;
      logic [AddrWidth-1:0]   alignment;
   } req_type;

   typedef struct packed {
      logic                      ok;
      logic [AddrWidth-1:0]      granted_address;
      logic [AddrWidth:0]        free_total;
      logic [FragCountWidth-1:0] fragment_count;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/aligned_range_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Aligned first-fit range allocator. Raise start for one cycle with an item on req_item
// while busy is low; busy then stays high until the item is finished, and the answer
// appears on rsp_item for exactly one cycle, flagged by rsp_valid. The receiver cannot
// stall, so capture rsp_item whenever rsp_valid is high. The free table lives in a
// memory with one write port and one registered read port, and every operation walks
// it under a small sequencer. Each table entry scanned takes a read, an align add, and
// an end add and compare; each entry moved when a range is inserted or removed takes a
// read and a write. A query always scans the whole table. csr_wdata sets the default
// alignment mask; write it only while busy is low and no answer is pending.
module aligned_range_allocator #(
   parameter int MAX_FRAGMENTS = aralloc_pkg::DefMaxFragments
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire aralloc_pkg::req_type                   req_item,
   output logic                                        rsp_valid,
   output aralloc_pkg::rsp_type                        rsp_item,
   input  wire logic                                   csr_we,
   input  wire logic [aralloc_pkg::AlignCfgWidth-1:0]  csr_wdata
);

   localparam int AW = aralloc_pkg::AddrWidth;
   localparam int IW = $clog2(MAX_FRAGMENTS);
   localparam int CW = $clog2(MAX_FRAGMENTS + 1);
   localparam int FW = aralloc_pkg::FragCountWidth;
   localparam logic [AW:0] TotalLimit = {1'b1, {AW{1'b0}}};

   // free table: {start, end} per entry, sorted by start
   logic [2*AW-1:0] mem [MAX_FRAGMENTS];
   logic [2*AW-1:0] rdata_ff;
   logic [IW-1:0]   raddr;
   logic            mem_we;
   logic [IW-1:0]   mem_waddr;
   logic [2*AW-1:0] mem_wdata;

   aralloc_pkg::state_type state_ff, state_in;
   aralloc_pkg::req_type   req_ff, req_in;
   aralloc_pkg::rsp_type   rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [aralloc_pkg::AlignCfgWidth-1:0] align_cfg_ff;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   sh_ff, sh_in;
   logic [CW-1:0]   at_ff, at_in;
   logic [AW-1:0]   sz_ff, sz_in;
   logic [AW-1:0]   mask_ff, mask_in;
   logic [AW-1:0]   szm1_ff, szm1_in;
   logic [AW:0]     de1_ff, de1_in;
   logic [AW:0]     de_ff, de_in;
   logic [AW:0]     tmp_ff, tmp_in;
   logic [AW:0]     acc_ff, acc_in;
   logic [AW-1:0]   d_ff, d_in;
   logic [AW-1:0]   dend_ff, dend_in;
   logic [AW-1:0]   cur_s_ff, cur_s_in, cur_e_ff, cur_e_in;
   logic [AW-1:0]   prev_s_ff, prev_s_in, prev_e_ff, prev_e_in;
   logic            head_ff, head_in, tail_ff, tail_in;
   logic            ok_ff, ok_in;
   logic [AW-1:0]   granted_ff, granted_in;
   logic            w0_en_ff, w0_en_in, w1_en_ff, w1_en_in;
   logic [IW-1:0]   w0_idx_ff, w0_idx_in, w1_idx_ff, w1_idx_in;
   logic [2*AW-1:0] w0_data_ff, w0_data_in, w1_data_ff, w1_data_in;

   // shared conditions
   logic [AW-1:0] dm, rd_s, rd_e;
   logic [AW:0]   de_prep, alloc_de, acc_sum;
   logic          zero_sz, table_empty, full, last;
   logic          alloc_fit, at_stop, at_fit, free_below;
   logic          carve_lo, carve_hi, up_done, dn_done, free_ins;

   always_comb begin
      dm          = AW'(align_cfg_ff);
      rd_s        = rdata_ff[2*AW-1:AW];
      rd_e        = rdata_ff[AW-1:0];
      zero_sz     = (req_ff.size == '0) || (sz_ff == '0);
      de_prep     = {1'b0, req_ff.address} + {1'b0, szm1_ff};
      alloc_de    = tmp_ff + {1'b0, szm1_ff};
      alloc_fit   = (tmp_ff[AW-1:0] >= rd_s) && !alloc_de[AW] && (alloc_de[AW-1:0] <= rd_e);
      at_stop     = rd_s > req_ff.address;
      at_fit      = de_ff[AW-1:0] <= rd_e;
      free_below  = rd_s < req_ff.address;
      acc_sum     = acc_ff + tmp_ff;
      table_empty = (count_ff == '0);
      full        = (count_ff == CW'(MAX_FRAGMENTS));
      last        = ({1'b0, idx_ff} + 1'b1) == {1'b0, count_ff};
      carve_lo    = d_ff != cur_s_ff;
      carve_hi    = dend_ff != cur_e_ff;
      up_done     = sh_ff == at_ff;
      dn_done     = ({1'b0, sh_ff} + 1'b1) >= {1'b0, count_ff};
      free_ins    = !head_ff && !tail_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         aralloc_pkg::ST_IDLE:  if (start) state_in = aralloc_pkg::ST_PREP1;
         aralloc_pkg::ST_PREP1: state_in = aralloc_pkg::ST_PREP2;
         aralloc_pkg::ST_PREP2: state_in = aralloc_pkg::ST_PREP3;
         aralloc_pkg::ST_PREP3: begin
            unique case (req_ff.opcode)
               aralloc_pkg::OP_QUERY:
                  state_in = table_empty ? aralloc_pkg::ST_DONE : aralloc_pkg::ST_READ;
               aralloc_pkg::OP_FREE:
                  if (zero_sz || de_prep[AW]) state_in = aralloc_pkg::ST_DONE;
                  else if (table_empty)       state_in = aralloc_pkg::ST_DEC;
                  else                        state_in = aralloc_pkg::ST_READ;
               aralloc_pkg::OP_ALLOC_AT:
                  if (zero_sz || de_prep[AW] || table_empty) state_in = aralloc_pkg::ST_DONE;
                  else                                       state_in = aralloc_pkg::ST_READ;
               default:
                  if (zero_sz || table_empty) state_in = aralloc_pkg::ST_DONE;
                  else                        state_in = aralloc_pkg::ST_READ;
            endcase
         end
         aralloc_pkg::ST_READ:  state_in = aralloc_pkg::ST_EVAL1;
         aralloc_pkg::ST_EVAL1: state_in = aralloc_pkg::ST_EVAL2;
         aralloc_pkg::ST_EVAL2: begin
            unique case (req_ff.opcode)
               aralloc_pkg::OP_ALLOC:
                  if (alloc_fit) state_in = aralloc_pkg::ST_CARVE;
                  else           state_in = last ? aralloc_pkg::ST_DONE : aralloc_pkg::ST_READ;
               aralloc_pkg::OP_ALLOC_AT:
                  if (at_stop)     state_in = aralloc_pkg::ST_DONE;
                  else if (at_fit) state_in = aralloc_pkg::ST_CARVE;
                  else             state_in = last ? aralloc_pkg::ST_DONE : aralloc_pkg::ST_READ;
               aralloc_pkg::OP_FREE:
                  if (free_below) state_in = last ? aralloc_pkg::ST_DEC : aralloc_pkg::ST_READ;
                  else            state_in = aralloc_pkg::ST_DEC;
               default:
                  state_in = last ? aralloc_pkg::ST_DONE : aralloc_pkg::ST_READ;
            endcase
         end
         aralloc_pkg::ST_CARVE: begin
            if (carve_lo && carve_hi)
               state_in = full ? aralloc_pkg::ST_DONE : aralloc_pkg::ST_SHUP_RD;
            else if (carve_lo || carve_hi)
               state_in = aralloc_pkg::ST_WR0;
            else
               state_in = aralloc_pkg::ST_SHDN_RD;
         end
         aralloc_pkg::ST_DEC: begin
            if (head_ff && tail_ff)
               state_in = aralloc_pkg::ST_SHDN_RD;
            else if (head_ff)
               state_in = (de_ff[AW-1:0] > prev_e_ff) ? aralloc_pkg::ST_WR0 : aralloc_pkg::ST_DONE;
            else if (tail_ff)
               state_in = (req_ff.address < cur_s_ff) ? aralloc_pkg::ST_WR0 : aralloc_pkg::ST_DONE;
            else
               state_in = full ? aralloc_pkg::ST_DONE : aralloc_pkg::ST_SHUP_RD;
         end
         aralloc_pkg::ST_SHUP_RD:
            state_in = up_done ? aralloc_pkg::ST_WR0 : aralloc_pkg::ST_SHUP_WR;
         aralloc_pkg::ST_SHUP_WR: state_in = aralloc_pkg::ST_SHUP_RD;
         aralloc_pkg::ST_SHDN_RD:
            if (!dn_done)      state_in = aralloc_pkg::ST_SHDN_WR;
            else if (w0_en_ff) state_in = aralloc_pkg::ST_WR0;
            else               state_in = aralloc_pkg::ST_DONE;
         aralloc_pkg::ST_SHDN_WR: state_in = aralloc_pkg::ST_SHDN_RD;
         aralloc_pkg::ST_WR0:
            state_in = w1_en_ff ? aralloc_pkg::ST_WR1 : aralloc_pkg::ST_DONE;
         aralloc_pkg::ST_WR1:  state_in = aralloc_pkg::ST_DONE;
         aralloc_pkg::ST_DONE: state_in = aralloc_pkg::ST_IDLE;
         default:              state_in = aralloc_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in       = req_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      sh_in        = sh_ff;
      at_in        = at_ff;
      sz_in        = sz_ff;
      mask_in      = mask_ff;
      szm1_in      = szm1_ff;
      de1_in       = de1_ff;
      de_in        = de_ff;
      tmp_in       = tmp_ff;
      acc_in       = acc_ff;
      d_in         = d_ff;
      dend_in      = dend_ff;
      cur_s_in     = cur_s_ff;
      cur_e_in     = cur_e_ff;
      prev_s_in    = prev_s_ff;
      prev_e_in    = prev_e_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      ok_in        = ok_ff;
      granted_in   = granted_ff;
      w0_en_in     = w0_en_ff;
      w1_en_in     = w1_en_ff;
      w0_idx_in    = w0_idx_ff;
      w1_idx_in    = w1_idx_ff;
      w0_data_in   = w0_data_ff;
      w1_data_in   = w1_data_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      raddr        = IW'(idx_ff);
      mem_we       = 1'b0;
      mem_waddr    = w0_idx_ff;
      mem_wdata    = w0_data_ff;
      unique case (state_ff)
         aralloc_pkg::ST_IDLE: begin
            // take the item and clear the per-item state
            req_in     = req_item;
            idx_in     = '0;
            acc_in     = '0;
            head_in    = 1'b0;
            tail_in    = 1'b0;
            ok_in      = 1'b0;
            granted_in = '0;
            w0_en_in   = 1'b0;
            w1_en_in   = 1'b0;
         end
         aralloc_pkg::ST_PREP1: begin
            sz_in   = (req_ff.size + dm) & ~dm;
            mask_in = (req_ff.alignment == '0) ? dm : req_ff.alignment - 1'b1;
         end
         aralloc_pkg::ST_PREP2: begin
            szm1_in = sz_ff - 1'b1;
            de1_in  = {1'b0, req_ff.address} + {1'b0, sz_ff};
         end
         aralloc_pkg::ST_PREP3: begin
            de_in = de_prep;
            if (req_ff.opcode == aralloc_pkg::OP_QUERY && table_empty) ok_in = 1'b1;
            if (req_ff.opcode == aralloc_pkg::OP_FREE && zero_sz)      ok_in = 1'b1;
         end
         aralloc_pkg::ST_READ: ;
         aralloc_pkg::ST_EVAL1: begin
            case (req_ff.opcode)
               aralloc_pkg::OP_ALLOC: tmp_in = {1'b0, (rd_s + mask_ff) & ~mask_ff};
               aralloc_pkg::OP_FREE:  tmp_in = {1'b0, rd_e} + 1'b1;
               default:               tmp_in = {1'b0, rd_e - rd_s} + 1'b1;
            endcase
         end
         aralloc_pkg::ST_EVAL2: begin
            cur_s_in = rd_s;
            cur_e_in = rd_e;
            unique case (req_ff.opcode)
               aralloc_pkg::OP_ALLOC: begin
                  d_in    = tmp_ff[AW-1:0];
                  dend_in = alloc_de[AW-1:0];
                  if (!alloc_fit) idx_in = idx_ff + 1'b1;
               end
               aralloc_pkg::OP_ALLOC_AT: begin
                  d_in    = req_ff.address;
                  dend_in = de_ff[AW-1:0];
                  if (!at_stop && !at_fit) idx_in = idx_ff + 1'b1;
               end
               aralloc_pkg::OP_FREE: begin
                  if (free_below) begin
                     head_in   = {1'b0, req_ff.address} <= tmp_ff;
                     prev_s_in = rd_s;
                     prev_e_in = rd_e;
                     idx_in    = idx_ff + 1'b1;
                  end else begin
                     tail_in = de1_ff >= {1'b0, rd_s};
                  end
               end
               default: begin
                  // saturating running total
                  acc_in = (acc_sum > TotalLimit) ? TotalLimit : acc_sum;
                  idx_in = idx_ff + 1'b1;
                  if (last) ok_in = 1'b1;
               end
            endcase
         end
         aralloc_pkg::ST_CARVE: begin
            granted_in = d_ff;
            w0_idx_in  = IW'(idx_ff);
            w1_idx_in  = IW'(idx_ff + 1'b1);
            w0_data_in = carve_lo ? {cur_s_ff, d_ff - 1'b1} : {dend_ff + 1'b1, cur_e_ff};
            w1_data_in = {dend_ff + 1'b1, cur_e_ff};
            ok_in      = !(carve_lo && carve_hi && full);
            if (!ok_in) granted_in = '0;
            w0_en_in   = carve_lo || carve_hi;
            w1_en_in   = carve_lo && carve_hi;
            sh_in      = (carve_lo && carve_hi) ? count_ff : idx_ff;
            at_in      = idx_ff + 1'b1;
         end
         aralloc_pkg::ST_DEC: begin
            ok_in = 1'b1;
            if (head_ff && tail_ff) begin
               // merge both neighbours, keep the larger end, drop the upper entry
               w0_en_in   = 1'b1;
               w0_idx_in  = IW'(idx_ff - 1'b1);
               w0_data_in = {prev_s_ff, (cur_e_ff > de_ff[AW-1:0]) ? cur_e_ff : de_ff[AW-1:0]};
               sh_in      = idx_ff;
            end else if (head_ff) begin
               w0_idx_in  = IW'(idx_ff - 1'b1);
               w0_data_in = {prev_s_ff, de_ff[AW-1:0]};
            end else if (tail_ff) begin
               w0_idx_in  = IW'(idx_ff);
               w0_data_in = {req_ff.address, cur_e_ff};
            end else begin
               ok_in      = !full;
               w0_idx_in  = IW'(idx_ff);
               w0_data_in = {req_ff.address, de_ff[AW-1:0]};
               sh_in      = count_ff;
               at_in      = idx_ff;
            end
         end
         aralloc_pkg::ST_SHUP_RD: begin
            raddr = IW'(sh_ff - 1'b1);
            if (up_done) count_in = count_ff + 1'b1;
         end
         aralloc_pkg::ST_SHUP_WR: begin
            mem_we    = 1'b1;
            mem_waddr = IW'(sh_ff);
            mem_wdata = rdata_ff;
            sh_in     = sh_ff - 1'b1;
         end
         aralloc_pkg::ST_SHDN_RD: begin
            raddr = IW'(sh_ff + 1'b1);
            if (dn_done) count_in = count_ff - 1'b1;
         end
         aralloc_pkg::ST_SHDN_WR: begin
            mem_we    = 1'b1;
            mem_waddr = IW'(sh_ff);
            mem_wdata = rdata_ff;
            sh_in     = sh_ff + 1'b1;
         end
         aralloc_pkg::ST_WR0: begin
            mem_we = 1'b1;
         end
         aralloc_pkg::ST_WR1: begin
            mem_we    = 1'b1;
            mem_waddr = w1_idx_ff;
            mem_wdata = w1_data_ff;
         end
         aralloc_pkg::ST_DONE: begin
            rsp_valid_in           = 1'b1;
            rsp_in.ok              = ok_ff;
            rsp_in.granted_address = ok_ff ? granted_ff : '0;
            rsp_in.free_total      = acc_ff;
            rsp_in.fragment_count  = (req_ff.opcode == aralloc_pkg::OP_QUERY) ?
                                     FW'(count_ff) : '0;
         end
         default: ;
      endcase
      if (req_ff.opcode == aralloc_pkg::OP_ALLOC_AT) granted_in = ok_in ? req_ff.address : '0;
   end

   // table memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rdata_ff <= mem[raddr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aralloc_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         align_cfg_ff <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) align_cfg_ff <= csr_wdata;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      idx_ff     <= idx_in;
      sh_ff      <= sh_in;
      at_ff      <= at_in;
      sz_ff      <= sz_in;
      mask_ff    <= mask_in;
      szm1_ff    <= szm1_in;
      de1_ff     <= de1_in;
      de_ff      <= de_in;
      tmp_ff     <= tmp_in;
      acc_ff     <= acc_in;
      d_ff       <= d_in;
      dend_ff    <= dend_in;
      cur_s_ff   <= cur_s_in;
      cur_e_ff   <= cur_e_in;
      prev_s_ff  <= prev_s_in;
      prev_e_ff  <= prev_e_in;
      head_ff    <= head_in;
      tail_ff    <= tail_in;
      ok_ff      <= ok_in;
      granted_ff <= granted_in;
      w0_en_ff   <= w0_en_in;
      w1_en_ff   <= w1_en_in;
      w0_idx_ff  <= w0_idx_in;
      w1_idx_ff  <= w1_idx_in;
      w0_data_ff <= w0_data_in;
      w1_data_ff <= w1_data_in;
   end

   assign busy      = (state_ff != aralloc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire
